// ===== rtl/rau_pkg.sv =====
// Package for the rational arithmetic unit: widths, operation and status codes,
// and sequencer state type. No dependencies.
package rau_pkg;
   localparam int VALUE_WIDTH = 32;
   localparam int DEN_WIDTH   = VALUE_WIDTH - 1;
   localparam int WIDE_WIDTH  = 2 * VALUE_WIDTH;
   localparam int CNT_WIDTH   = $clog2(WIDE_WIDTH + 1);

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_OVF  = 2'd1,
      ST_DIVZ = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL1,
      S_MUL2,
      S_MUL3,
      S_SUM,
      S_MAG,
      S_GCD_START,
      S_GCD_WAIT,
      S_DIVN_START,
      S_DIVN_WAIT,
      S_DIVD_START,
      S_DIVD_WAIT,
      S_CHECK,
      S_DONE
   } state_type;
endpackage

// ===== rtl/rau_divider.sv =====
// Shared restoring divider: one quotient bit per cycle over WIDE_WIDTH-bit operands.
// Depends on rau_pkg.
module rau_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [rau_pkg::WIDE_WIDTH-1:0] dividend,
   input  logic [rau_pkg::WIDE_WIDTH-1:0] divisor,
   output logic                           busy,
   output logic [rau_pkg::WIDE_WIDTH-1:0] quotient
);
   logic [rau_pkg::WIDE_WIDTH-1:0] quo_ff, quo_in;
   logic [rau_pkg::WIDE_WIDTH-1:0] rem_ff, rem_in;
   logic [rau_pkg::WIDE_WIDTH-1:0] dvs_ff, dvs_in;
   logic [rau_pkg::CNT_WIDTH-1:0]  cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic [rau_pkg::WIDE_WIDTH:0]   trial;
   logic [rau_pkg::WIDE_WIDTH:0]   diff;

   // Shift one dividend bit into the partial remainder and try a subtract
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff, quo_ff[rau_pkg::WIDE_WIDTH-1]};
      diff    = trial - {1'b0, dvs_ff};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = rau_pkg::CNT_WIDTH'(rau_pkg::WIDE_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[rau_pkg::WIDE_WIDTH]) begin
            rem_in = diff[rau_pkg::WIDE_WIDTH-1:0];
            quo_in = {quo_ff[rau_pkg::WIDE_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = trial[rau_pkg::WIDE_WIDTH-1:0];
            quo_in = {quo_ff[rau_pkg::WIDE_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == rau_pkg::CNT_WIDTH'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
endmodule

// ===== rtl/rau_gcd.sv =====
// Binary gcd engine: strips common twos, then subtract-and-shift until one value is zero.
// Depends on rau_pkg.
module rau_gcd (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [rau_pkg::WIDE_WIDTH-1:0] x,
   input  logic [rau_pkg::WIDE_WIDTH-1:0] y,
   output logic                           busy,
   output logic [rau_pkg::WIDE_WIDTH-1:0] gcd
);
   logic [rau_pkg::WIDE_WIDTH-1:0] u_ff, u_in;
   logic [rau_pkg::WIDE_WIDTH-1:0] v_ff, v_in;
   logic [rau_pkg::CNT_WIDTH-1:0]  k_ff, k_in;
   logic                           busy_ff, busy_in;
   logic [rau_pkg::WIDE_WIDTH-1:0] big, sml, dif;

   // One step a cycle: halve even values, else subtract smaller from larger
   always_comb begin
      u_in    = u_ff;
      v_in    = v_ff;
      k_in    = k_ff;
      busy_in = busy_ff;
      big     = (u_ff > v_ff) ? u_ff : v_ff;
      sml     = (u_ff > v_ff) ? v_ff : u_ff;
      dif     = big - sml;
      if (start) begin
         u_in    = x;
         v_in    = y;
         k_in    = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (u_ff == '0 || v_ff == '0) begin
            busy_in = 1'b0;
            u_in    = (u_ff | v_ff) << k_ff;
         end else if (!u_ff[0] && !v_ff[0]) begin
            u_in = u_ff >> 1;
            v_in = v_ff >> 1;
            k_in = k_ff + 1'b1;
         end else if (!u_ff[0]) begin
            u_in = u_ff >> 1;
         end else if (!v_ff[0]) begin
            v_in = v_ff >> 1;
         end else begin
            u_in = sml;
            v_in = dif >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      u_ff <= u_in;
      v_ff <= v_in;
      k_ff <= k_in;
   end

   assign busy = busy_ff;
   assign gcd  = u_ff;
endmodule

// ===== rtl/rational_arithmetic_unit_core.sv =====
// Rational arithmetic unit: combines two fractions with add, subtract, multiply or divide
// and returns the result in lowest terms with a positive denominator, or a status code.
// One word is taken at a time; req_stall stays high until the result word is taken.
// An item takes three products on one shared 33x33 multiplier and a sum, a binary gcd
// (one shift or subtract per step over 64-bit values, fewer steps for small operands),
// and two 64-step divisions on one shared restoring divider before the result word.
// A zero denominator or a divide by a zero fraction goes straight to the result word
// with a DIVZ status; a zero result numerator skips the gcd and the divisions.
// Depends on rau_pkg, rau_gcd and rau_divider.
module rational_arithmetic_unit_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_operation,
   input  logic signed [rau_pkg::VALUE_WIDTH-1:0] req_a_num,
   input  logic [rau_pkg::DEN_WIDTH-1:0]   req_a_den,
   input  logic signed [rau_pkg::VALUE_WIDTH-1:0] req_b_num,
   input  logic [rau_pkg::DEN_WIDTH-1:0]   req_b_den,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [rau_pkg::VALUE_WIDTH-1:0] rsp_result_num,
   output logic [rau_pkg::DEN_WIDTH-1:0]   rsp_result_den,
   output logic [1:0]                      rsp_status
);
   localparam int VW = rau_pkg::VALUE_WIDTH;
   localparam int WW = rau_pkg::WIDE_WIDTH;
   localparam int DW = rau_pkg::DEN_WIDTH;

   rau_pkg::state_type state_ff, state_in;
   rau_pkg::op_type    op_ff, op_in;
   logic signed [VW-1:0] an_ff, an_in, bn_ff, bn_in;
   logic [DW-1:0]        ad_ff, ad_in, bd_ff, bd_in;
   logic signed [WW-1:0] p1_ff, p1_in, p2_ff, p2_in, den_ff, den_in;
   logic [WW-1:0]        nmag_ff, nmag_in, dmag_ff, dmag_in, g_ff, g_in;
   logic                 neg_ff, neg_in;
   logic signed [VW-1:0] onum_ff, onum_in;
   logic [DW-1:0]        oden_ff, oden_in;
   rau_pkg::status_type  ost_ff, ost_in;

   // Shared multiplier
   logic signed [VW:0]   mul_a, mul_b;
   logic signed [WW+1:0] mul_p;

   logic          gcd_start, gcd_busy;
   logic [WW-1:0] gcd_val;
   logic          div_start, div_busy;
   logic [WW-1:0] div_dividend, div_q;
   logic signed [WW-1:0] sum;
   logic [WW-1:0] lim;

   assign mul_p = mul_a * mul_b;

   rau_gcd u_gcd (
      .clock (clock), .reset (reset), .start (gcd_start),
      .x (nmag_ff), .y (dmag_ff), .busy (gcd_busy), .gcd (gcd_val)
   );

   rau_divider u_div (
      .clock (clock), .reset (reset), .start (div_start),
      .dividend (div_dividend), .divisor (g_ff),
      .busy (div_busy), .quotient (div_q)
   );

   // Sequence products, gcd, the two divisions and the range check
   always_comb begin
      state_in = state_ff;
      op_in = op_ff; an_in = an_ff; bn_in = bn_ff; ad_in = ad_ff; bd_in = bd_ff;
      p1_in = p1_ff; p2_in = p2_ff; den_in = den_ff;
      nmag_in = nmag_ff; dmag_in = dmag_ff; g_in = g_ff; neg_in = neg_ff;
      onum_in = onum_ff; oden_in = oden_ff; ost_in = ost_ff;
      mul_a = '0; mul_b = '0;
      gcd_start = 1'b0; div_start = 1'b0; div_dividend = nmag_ff;
      sum = '0;
      lim = WW'(1) << (VW - 1);
      unique case (state_ff)
         rau_pkg::S_IDLE: begin
            if (req_valid) begin
               op_in = rau_pkg::op_type'(req_operation);
               an_in = req_a_num; bn_in = req_b_num;
               ad_in = req_a_den; bd_in = req_b_den;
               if (req_a_den == '0 || req_b_den == '0 ||
                   (req_operation == rau_pkg::OP_DIV && req_b_num == '0)) begin
                  onum_in = '0; oden_in = DW'(1); ost_in = rau_pkg::ST_DIVZ;
                  state_in = rau_pkg::S_DONE;
               end else begin
                  state_in = rau_pkg::S_MUL1;
               end
            end
         end
         rau_pkg::S_MUL1: begin
            // numerator term one: a_num * b_den, or a_num * b_num for multiply
            mul_a = {an_ff[VW-1], an_ff};
            mul_b = (op_ff == rau_pkg::OP_MUL) ? {bn_ff[VW-1], bn_ff} : {2'b00, bd_ff};
            p1_in = mul_p[WW-1:0];
            state_in = rau_pkg::S_MUL2;
         end
         rau_pkg::S_MUL2: begin
            // b_num * a_den
            mul_a = {bn_ff[VW-1], bn_ff};
            mul_b = {2'b00, ad_ff};
            p2_in = mul_p[WW-1:0];
            state_in = rau_pkg::S_MUL3;
         end
         rau_pkg::S_MUL3: begin
            // denominator: a_den * b_den, or a_den * b_num for divide
            mul_a = {2'b00, ad_ff};
            mul_b = (op_ff == rau_pkg::OP_DIV) ? {bn_ff[VW-1], bn_ff} : {2'b00, bd_ff};
            den_in = mul_p[WW-1:0];
            state_in = rau_pkg::S_SUM;
         end
         rau_pkg::S_SUM: begin
            unique case (op_ff)
               rau_pkg::OP_ADD: sum = p1_ff + p2_ff;
               rau_pkg::OP_SUB: sum = p1_ff - p2_ff;
               rau_pkg::OP_MUL: sum = p1_ff;
               rau_pkg::OP_DIV: sum = p1_ff;
               default:         sum = p1_ff;
            endcase
            p1_in = sum;
            state_in = rau_pkg::S_MAG;
         end
         rau_pkg::S_MAG: begin
            neg_in  = p1_ff[WW-1] != den_ff[WW-1];
            nmag_in = p1_ff[WW-1] ? WW'(-p1_ff) : WW'(p1_ff);
            dmag_in = den_ff[WW-1] ? WW'(-den_ff) : WW'(den_ff);
            if (p1_ff == '0) begin
               onum_in = '0; oden_in = DW'(1); ost_in = rau_pkg::ST_OK;
               state_in = rau_pkg::S_DONE;
            end else begin
               state_in = rau_pkg::S_GCD_START;
            end
         end
         rau_pkg::S_GCD_START: begin
            gcd_start = 1'b1;
            state_in = rau_pkg::S_GCD_WAIT;
         end
         rau_pkg::S_GCD_WAIT: begin
            if (!gcd_busy) begin
               g_in = gcd_val;
               state_in = rau_pkg::S_DIVN_START;
            end
         end
         rau_pkg::S_DIVN_START: begin
            div_start = 1'b1;
            div_dividend = nmag_ff;
            state_in = rau_pkg::S_DIVN_WAIT;
         end
         rau_pkg::S_DIVN_WAIT: begin
            if (!div_busy) begin
               nmag_in = div_q;
               state_in = rau_pkg::S_DIVD_START;
            end
         end
         rau_pkg::S_DIVD_START: begin
            div_start = 1'b1;
            div_dividend = dmag_ff;
            state_in = rau_pkg::S_DIVD_WAIT;
         end
         rau_pkg::S_DIVD_WAIT: begin
            if (!div_busy) begin
               dmag_in = div_q;
               state_in = rau_pkg::S_CHECK;
            end
         end
         rau_pkg::S_CHECK: begin
            if (dmag_ff > lim - 1'b1 || nmag_ff > (neg_ff ? lim : lim - 1'b1)) begin
               onum_in = '0; oden_in = DW'(1); ost_in = rau_pkg::ST_OVF;
            end else begin
               onum_in = neg_ff ? VW'(-nmag_ff) : nmag_ff[VW-1:0];
               oden_in = dmag_ff[DW-1:0];
               ost_in  = rau_pkg::ST_OK;
            end
            state_in = rau_pkg::S_DONE;
         end
         rau_pkg::S_DONE: begin
            if (!rsp_stall) state_in = rau_pkg::S_IDLE;
         end
         default: state_in = rau_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rau_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff <= op_in; an_ff <= an_in; bn_ff <= bn_in; ad_ff <= ad_in; bd_ff <= bd_in;
      p1_ff <= p1_in; p2_ff <= p2_in; den_ff <= den_in;
      nmag_ff <= nmag_in; dmag_ff <= dmag_in; g_ff <= g_in; neg_ff <= neg_in;
      onum_ff <= onum_in; oden_ff <= oden_in; ost_ff <= ost_in;
   end

   assign req_stall      = state_ff != rau_pkg::S_IDLE;
   assign rsp_valid      = state_ff == rau_pkg::S_DONE;
   assign rsp_result_num = onum_ff;
   assign rsp_result_den = oden_ff;
   assign rsp_status     = ost_ff;
endmodule

// ===== rtl/rau_checker.sv =====
// Port-level checker for the rational arithmetic unit, bound to the top level.
// Depends on rau_pkg.
module rau_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic signed [rau_pkg::VALUE_WIDTH-1:0] rsp_result_num,
   input logic [rau_pkg::DEN_WIDTH-1:0]      rsp_result_den,
   input logic [1:0]                         rsp_status
);
   // Accepting a word closes the input until the result is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall) else $error("input not closed");

   // Never take input while a result waits
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("input open with result pending");

   // A failed status carries 0/1
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != rau_pkg::ST_OK |->
      rsp_result_num == '0 && rsp_result_den == rau_pkg::DEN_WIDTH'(1))
      else $error("bad failure payload");

   // Denominator always positive, status a known code
   a_den_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_result_den != '0 && rsp_status <= rau_pkg::ST_DIVZ)
      else $error("bad result");

   // Stalled result stays valid and its numerator holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_num))
      else $error("result dropped");
endmodule

bind rational_arithmetic_unit_core rau_checker u_rau_checker (.*);
